### rtl/smx_pkg.sv
// Shared types, opcodes and sizes of the stack machine execute unit.
`timescale 1ns / 1ps
package smx_pkg;

	localparam int OPERAND_DEPTH = 1024;
	localparam int LOCAL_DEPTH   = 1024;
	localparam int CALL_DEPTH    = 256;

	localparam int OP_AW   = $clog2(OPERAND_DEPTH);
	localparam int OP_CW   = OP_AW + 1;
	localparam int LOC_AW  = $clog2(LOCAL_DEPTH);
	localparam int LOC_CW  = LOC_AW + 1;
	localparam int CALL_AW = $clog2(CALL_DEPTH);
	localparam int CALL_CW = CALL_AW + 1;
	// wide enough for frame sums with a 16-bit slot or an 11-bit frame size
	localparam int LSUM_W  = ((LOC_CW > 16) ? LOC_CW : 16) + 1;

	typedef enum logic [4:0] {
		OP_NOOP  = 5'd0,
		OP_LDL   = 5'd1,
		OP_PUSH  = 5'd2,
		OP_LTI   = 5'd3,
		OP_LT    = 5'd4,
		OP_GT    = 5'd6,
		OP_EQ    = 5'd8,
		OP_NE    = 5'd9,
		OP_NOT   = 5'd10,
		OP_JMPF  = 5'd11,
		OP_RET   = 5'd12,
		OP_ADDI  = 5'd13,
		OP_ADD   = 5'd14,
		OP_SUBI  = 5'd15,
		OP_SUB   = 5'd16,
		OP_MUL   = 5'd18,
		OP_DIV   = 5'd20,
		OP_MOD   = 5'd22,
		OP_CALL  = 5'd23,
		OP_PRINT = 5'd24,
		OP_STR0  = 5'd25,
		OP_STR1  = 5'd26,
		OP_STR2  = 5'd27,
		OP_EXIT  = 5'd28
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_UNKNOWN  = 3'd1,
		ST_UNDER    = 3'd2,
		ST_OVER     = 3'd3,
		ST_FRAME    = 3'd4,
		ST_DIVZERO  = 3'd5,
		ST_UNSUP    = 3'd6
	} status_t;

	typedef enum logic [3:0] {
		CL_NOOP, CL_PUSH, CL_BIN, CL_NOT, CL_JMPF, CL_RET, CL_CALL,
		CL_PRINT, CL_UNSUP, CL_EXIT, CL_UNKNOWN
	} cls_t;

	typedef enum logic [3:0] {
		AL_LT, AL_GT, AL_EQ, AL_NE, AL_ADD, AL_SUB, AL_MUL, AL_DIV, AL_MOD
	} alu_op_t;

	typedef enum logic [3:0] {
		BS_IDLE, BS_DEC, BS_LWAIT, BS_RB, BS_RA, BS_ALU, BS_R1, BS_LINK,
		BS_CPY, BS_CPYEND, BS_OUT
	} back_state_t;

	typedef enum logic [1:0] {
		AS_IDLE, AS_MUL, AS_DIV
	} alu_state_t;

	typedef struct packed {
		cls_t        cls;
		alu_op_t     aop;
		logic        use_local;
		logic        b_zero;
		logic [15:0] idx;
		logic [63:0] imm;
		logic [10:0] cfw;
		logic [7:0]  argc;
	} item_t;

	typedef struct packed {
		logic [15:0] nf;
		logic [15:0] np;
		logic        pv;
		logic [63:0] pval;
		logic        halted;
		status_t     st;
	} result_t;

	typedef struct packed {
		logic [15:0]       fn;
		logic [15:0]       pc;
		logic [LOC_CW-1:0] base;
	} link_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

endpackage

### rtl/stack_machine_execute_unit.sv
// Top level of the stack machine execute unit.
// Usage:
//   Instruction beats enter through push/full: one beat is taken on a clock
//   edge with push high and full low. Result beats leave through empty/pop:
//   the oldest result is shown while empty is low and is taken with pop.
//   root_frame_words is written with root_frame_words_we while the unit is idle.
// Sequencing:
//   A two-entry front queue decouples the input from the executor, which
//   takes a new beat only once the result of the last one has entered the
//   result queue. Div and mod find one quotient bit per cycle; a call
//   copies one argument per cycle.
// Reset:
//   Asynchronous reset empties both queues, clears stack tops, link depth,
//   program location and halt, and sets the root frame to one word. The
//   memories are not cleared; no clearing pass is needed.
// Stalls:
//   A result that is not popped holds; a second result queues behind it and
//   the executor waits with the next; full rises once two beats are queued.
`timescale 1ns / 1ps
module stack_machine_execute_unit import smx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [4:0]  opcode,
	input  logic [15:0] index_field,
	input  logic [63:0] immediate,
	input  logic [10:0] callee_frame_words,
	input  logic [7:0]  callee_arg_count,
	input  logic        root_frame_words_we,
	input  logic [10:0] root_frame_words,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] next_func,
	output logic [15:0] next_pc,
	output logic        print_valid,
	output logic [63:0] print_value,
	output logic        halted,
	output logic [2:0]  status
);

	item_t   head;
	logic    head_valid, deq;
	result_t res;

	smx_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .opcode(opcode),
		.index_field(index_field), .immediate(immediate),
		.callee_frame_words(callee_frame_words), .callee_arg_count(callee_arg_count),
		.deq(deq), .head_valid(head_valid), .head(head)
	);

	smx_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg_we(root_frame_words_we),
		.cfg_root(root_frame_words), .head_valid(head_valid), .head(head), .deq(deq),
		.res_pop(pop), .res_empty(empty), .res(res)
	);

	// drive result ports from the head of the result queue
	assign next_func   = res.nf;
	assign next_pc     = res.np;
	assign print_valid = res.pv;
	assign print_value = res.pval;
	assign halted      = res.halted;
	assign status      = res.st;

endmodule

### rtl/smx_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module smx_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	// write and read one entry per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/smx_front.sv
// Front end: accepts instruction beats, classifies them, queues them for the back end.
`timescale 1ns / 1ps
module smx_front import smx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [4:0]  opcode,
	input  logic [15:0] index_field,
	input  logic [63:0] immediate,
	input  logic [10:0] callee_frame_words,
	input  logic [7:0]  callee_arg_count,
	input  logic        deq,
	output logic        head_valid,
	output item_t       head
);

	item_t      cls_item;
	item_t      fq_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       enq;

	// classify the incoming opcode
	always_comb begin
		cls_item           = '0;
		cls_item.idx       = index_field;
		cls_item.imm       = immediate;
		cls_item.cfw       = callee_frame_words;
		cls_item.argc      = callee_arg_count;
		cls_item.cls       = CL_UNKNOWN;
		cls_item.aop       = AL_ADD;
		cls_item.use_local = 1'b0;
		cls_item.b_zero    = 1'b0;
		case (opcode_t'(opcode))
			OP_NOOP: cls_item.cls = CL_NOOP;
			OP_LDL: begin
				cls_item.cls       = CL_PUSH;
				cls_item.use_local = 1'b1;
				cls_item.b_zero    = 1'b1;
			end
			OP_PUSH: begin
				cls_item.cls    = CL_PUSH;
				cls_item.b_zero = 1'b1;
			end
			OP_LTI: begin
				cls_item.cls       = CL_PUSH;
				cls_item.use_local = 1'b1;
				cls_item.aop       = AL_LT;
			end
			OP_ADDI: begin
				cls_item.cls       = CL_PUSH;
				cls_item.use_local = 1'b1;
			end
			OP_SUBI: begin
				cls_item.cls       = CL_PUSH;
				cls_item.use_local = 1'b1;
				cls_item.aop       = AL_SUB;
			end
			OP_LT: begin
				cls_item.cls = CL_BIN;
				cls_item.aop = AL_LT;
			end
			OP_GT: begin
				cls_item.cls = CL_BIN;
				cls_item.aop = AL_GT;
			end
			OP_EQ: begin
				cls_item.cls = CL_BIN;
				cls_item.aop = AL_EQ;
			end
			OP_NE: begin
				cls_item.cls = CL_BIN;
				cls_item.aop = AL_NE;
			end
			OP_ADD: cls_item.cls = CL_BIN;
			OP_SUB: begin
				cls_item.cls = CL_BIN;
				cls_item.aop = AL_SUB;
			end
			OP_MUL: begin
				cls_item.cls = CL_BIN;
				cls_item.aop = AL_MUL;
			end
			OP_DIV: begin
				cls_item.cls = CL_BIN;
				cls_item.aop = AL_DIV;
			end
			OP_MOD: begin
				cls_item.cls = CL_BIN;
				cls_item.aop = AL_MOD;
			end
			OP_NOT:   cls_item.cls = CL_NOT;
			OP_JMPF:  cls_item.cls = CL_JMPF;
			OP_RET:   cls_item.cls = CL_RET;
			OP_CALL:  cls_item.cls = CL_CALL;
			OP_PRINT: cls_item.cls = CL_PRINT;
			OP_STR0, OP_STR1, OP_STR2: cls_item.cls = CL_UNSUP;
			OP_EXIT:  cls_item.cls = CL_EXIT;
			default:  cls_item.cls = CL_UNKNOWN;
		endcase
	end

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head       = fq_q[rp_q];
	assign enq        = push && !full;

	// two-entry queue toward the back end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (enq) begin
				wp_q <= ~wp_q;
			end
			if (deq) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, enq} - {1'b0, deq};
		end
	end

	always_ff @(posedge clk) begin
		if (enq) begin
			fq_q[wp_q] <= cls_item;
		end
	end

endmodule

### rtl/smx_alu.sv
// Arithmetic unit: registered compare/add/sub, four-step multiply, bit-serial divide.
`timescale 1ns / 1ps
module smx_alu import smx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  alu_req_t    req,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] result
);

	alu_state_t  state_q, state_d;
	logic [5:0]  cnt_q;
	logic        done_q;
	logic [63:0] res_q;
	logic [63:0] a_q, b_q, rem_q, acc_q;
	logic [31:0] p1_q, p2_q;
	logic        mod_q;
	logic [31:0] mx, my;
	logic [63:0] prod;
	logic [64:0] trial;
	logic        qbit;
	logic [63:0] rem_nx;

	// shared 32x32 multiplier
	always_comb begin
		case (cnt_q[1:0])
			2'd0:    begin mx = a_q[31:0];  my = b_q[31:0];  end
			2'd1:    begin mx = a_q[63:32]; my = b_q[31:0];  end
			default: begin mx = a_q[31:0];  my = b_q[63:32]; end
		endcase
	end
	assign prod = mx * my;

	// one restoring divide step
	assign trial  = {rem_q, a_q[63]};
	assign qbit   = (trial >= {1'b0, b_q});
	assign rem_nx = qbit ? 64'(trial - {1'b0, b_q}) : trial[63:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			AS_IDLE: begin
				if (req.start && req.op == AL_MUL) begin
					state_d = AS_MUL;
				end else if (req.start && (req.op == AL_DIV || req.op == AL_MOD)) begin
					state_d = AS_DIV;
				end
			end
			AS_MUL: if (cnt_q == 6'd3) state_d = AS_IDLE;
			AS_DIV: if (cnt_q == 6'd63) state_d = AS_IDLE;
			default: state_d = AS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= AS_IDLE;
			cnt_q   <= 6'd0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (state_q == AS_IDLE) begin
				cnt_q  <= 6'd0;
				done_q <= req.start && req.op != AL_MUL && req.op != AL_DIV &&
					req.op != AL_MOD;
			end else begin
				cnt_q <= cnt_q + 6'd1;
				if (state_d == AS_IDLE) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// operand capture, partial products and divide iteration
	always_ff @(posedge clk) begin
		case (state_q)
			AS_IDLE: begin
				a_q   <= a;
				b_q   <= b;
				rem_q <= 64'd0;
				mod_q <= (req.op == AL_MOD);
				case (req.op)
					AL_LT:   res_q <= {63'd0, a < b};
					AL_GT:   res_q <= {63'd0, a > b};
					AL_EQ:   res_q <= {63'd0, a == b};
					AL_NE:   res_q <= {63'd0, a != b};
					AL_SUB:  res_q <= a - b;
					default: res_q <= a + b;
				endcase
			end
			AS_MUL: begin
				case (cnt_q[1:0])
					2'd0:    acc_q <= prod;
					2'd1:    p1_q  <= prod[31:0];
					2'd2:    p2_q  <= prod[31:0];
					default: res_q <= acc_q + {p1_q + p2_q, 32'd0};
				endcase
			end
			AS_DIV: begin
				rem_q <= rem_nx;
				a_q   <= {a_q[62:0], qbit};
				if (cnt_q == 6'd63) begin
					res_q <= mod_q ? rem_nx : {a_q[62:0], qbit};
				end
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

### rtl/smx_back.sv
// Back end: executes queued instructions against the stacks and frames, queues results.
`timescale 1ns / 1ps
module smx_back import smx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [10:0] cfg_root,
	input  logic        head_valid,
	input  item_t       head,
	output logic        deq,
	input  logic        res_pop,
	output logic        res_empty,
	output result_t     res
);

	localparam int LINK_W = $bits(link_t);

	back_state_t       state_q, state_d;
	item_t             it_q, it_d;
	logic [OP_CW-1:0]  top_q, top_d, tm1, tm2, tmc;
	logic [LOC_CW-1:0] fbase_q, fbase_d, ftop_q, ftop_d, root_q, root_d;
	logic [CALL_CW-1:0] ltop_q, ltop_d, lm1;
	logic [15:0]       fn_q, fn_d, pc_q, pc_d, pc_inc;
	logic              halt_q, halt_d;
	status_t           hst_q, hst_d;
	logic [63:0]       b_q, b_d;
	logic [7:0]        cnt_q, cnt_d;
	logic              cpy_wv_q;
	logic [LOC_AW-1:0] cpy_wa_q, cpy_wa_d;
	result_t           res_q, res_d;

	logic              op_we;
	logic [OP_AW-1:0]  op_wa, op_ra;
	logic [63:0]       op_wd, op_rd;
	logic [LOC_AW-1:0] loc_ra;
	logic [63:0]       loc_rd;
	logic              lk_we;
	logic [LINK_W-1:0] lk_wd, lk_rd;
	link_t             lk_rec, lk_new;

	alu_req_t          alu_req;
	logic [63:0]       alu_a, alu_b, alu_res;
	logic              alu_done;

	logic [LSUM_W-1:0] lsum, csum, cwa, rsat, root_ext;

	logic              fin_ok, fin_err;
	status_t           err_code;
	logic [15:0]       nf_new, np_new;
	logic              pv_new;
	logic [63:0]       pval_new;

	result_t           oq_q [2];
	logic              owp_q, orp_q;
	logic [1:0]        ocnt_q;
	logic              opush;

	smx_ram #(.W(64), .D(OPERAND_DEPTH)) u_operand (
		.clk(clk), .we(op_we), .waddr(op_wa), .wdata(op_wd), .raddr(op_ra), .rdata(op_rd)
	);

	smx_ram #(.W(64), .D(LOCAL_DEPTH)) u_local (
		.clk(clk), .we(cpy_wv_q), .waddr(cpy_wa_q), .wdata(op_rd), .raddr(loc_ra),
		.rdata(loc_rd)
	);

	smx_ram #(.W(LINK_W), .D(CALL_DEPTH)) u_link (
		.clk(clk), .we(lk_we), .waddr(ltop_q[CALL_AW-1:0]), .wdata(lk_wd),
		.raddr(lm1[CALL_AW-1:0]), .rdata(lk_rd)
	);

	smx_alu u_alu (
		.clk(clk), .arst_n(arst_n), .req(alu_req), .a(alu_a), .b(alu_b),
		.done(alu_done), .result(alu_res)
	);

	assign tm1    = top_q - OP_CW'(1);
	assign tm2    = top_q - OP_CW'(2);
	assign tmc    = top_q - OP_CW'(1) - OP_CW'(cnt_q);
	assign lm1    = ltop_q - CALL_CW'(1);
	assign pc_inc = pc_q + 16'd1;
	assign lsum   = LSUM_W'(fbase_q) + LSUM_W'(it_q.idx);
	assign csum   = LSUM_W'(ftop_q) + LSUM_W'(it_q.cfw);
	assign cwa    = LSUM_W'(ftop_q) + LSUM_W'(it_q.argc) - LSUM_W'(1) - LSUM_W'(cnt_q);
	assign lk_rec = link_t'(lk_rd);
	assign lk_new = '{fn: fn_q, pc: pc_q, base: fbase_q};
	assign lk_wd  = LINK_W'(lk_new);

	// saturate the root frame size to one through the local store depth
	assign root_ext = LSUM_W'(cfg_root);
	always_comb begin
		if (root_ext == '0) begin
			rsat = LSUM_W'(1);
		end else if (root_ext > LSUM_W'(LOCAL_DEPTH)) begin
			rsat = LSUM_W'(LOCAL_DEPTH);
		end else begin
			rsat = root_ext;
		end
	end

	// sequence one instruction; finish with a result beat
	always_comb begin
		state_d  = state_q;
		it_d     = it_q;
		top_d    = top_q;
		fbase_d  = fbase_q;
		ftop_d   = ftop_q;
		root_d   = root_q;
		ltop_d   = ltop_q;
		fn_d     = fn_q;
		pc_d     = pc_q;
		halt_d   = halt_q;
		hst_d    = hst_q;
		b_d      = b_q;
		cnt_d    = cnt_q;
		cpy_wa_d = cpy_wa_q;
		res_d    = res_q;
		deq      = 1'b0;
		op_we    = 1'b0;
		op_wa    = top_q[OP_AW-1:0];
		op_wd    = alu_res;
		op_ra    = tm1[OP_AW-1:0];
		loc_ra   = lsum[LOC_AW-1:0];
		lk_we    = 1'b0;
		alu_req  = '{start: 1'b0, op: it_q.aop};
		alu_a    = op_rd;
		alu_b    = b_q;
		fin_ok   = 1'b0;
		fin_err  = 1'b0;
		err_code = ST_OK;
		nf_new   = fn_q;
		np_new   = pc_inc;
		pv_new   = 1'b0;
		pval_new = 64'd0;

		case (state_q)
			BS_IDLE: begin
				if (head_valid) begin
					deq     = 1'b1;
					it_d    = head;
					state_d = BS_DEC;
				end
			end
			BS_DEC: begin
				if (halt_q) begin
					fin_err  = 1'b1;
					err_code = hst_q;
				end else begin
					case (it_q.cls)
						CL_NOOP: fin_ok = 1'b1;
						CL_PUSH: begin
							if (it_q.use_local && lsum >= LSUM_W'(ftop_q)) begin
								fin_err  = 1'b1;
								err_code = ST_FRAME;
							end else if (top_q >= OP_CW'(OPERAND_DEPTH)) begin
								fin_err  = 1'b1;
								err_code = ST_OVER;
							end else if (it_q.use_local) begin
								state_d = BS_LWAIT;
							end else begin
								alu_req.start = 1'b1;
								alu_a         = it_q.imm;
								alu_b         = 64'd0;
								state_d       = BS_ALU;
							end
						end
						CL_BIN: begin
							if (top_q < OP_CW'(2)) begin
								fin_err  = 1'b1;
								err_code = ST_UNDER;
							end else begin
								state_d = BS_RB;
							end
						end
						CL_NOT, CL_JMPF, CL_PRINT: begin
							if (top_q == '0) begin
								fin_err  = 1'b1;
								err_code = ST_UNDER;
							end else begin
								state_d = BS_R1;
							end
						end
						CL_RET: begin
							if (ltop_q == '0) begin
								fin_err  = 1'b1;
								err_code = ST_UNDER;
							end else begin
								state_d = BS_LINK;
							end
						end
						CL_CALL: begin
							if (ltop_q >= CALL_CW'(CALL_DEPTH) ||
								csum > LSUM_W'(LOCAL_DEPTH) ||
								{3'd0, it_q.argc} > it_q.cfw) begin
								fin_err  = 1'b1;
								err_code = ST_FRAME;
							end else if (LSUM_W'(top_q) < LSUM_W'(it_q.argc)) begin
								fin_err  = 1'b1;
								err_code = ST_UNDER;
							end else begin
								lk_we  = 1'b1;
								ltop_d = ltop_q + CALL_CW'(1);
								cnt_d  = 8'd0;
								if (it_q.argc == 8'd0) begin
									fbase_d = ftop_q;
									ftop_d  = csum[LOC_CW-1:0];
									nf_new  = it_q.idx;
									np_new  = 16'd0;
									fin_ok  = 1'b1;
								end else begin
									state_d = BS_CPY;
								end
							end
						end
						CL_UNSUP: begin
							fin_err  = 1'b1;
							err_code = ST_UNSUP;
						end
						CL_EXIT: fin_err = 1'b1;
						default: begin
							fin_err  = 1'b1;
							err_code = ST_UNKNOWN;
						end
					endcase
				end
			end
			BS_LWAIT: begin
				alu_req.start = 1'b1;
				alu_a         = loc_rd;
				alu_b         = it_q.b_zero ? 64'd0 : it_q.imm;
				state_d       = BS_ALU;
			end
			BS_RB: begin
				b_d     = op_rd;
				op_ra   = tm2[OP_AW-1:0];
				state_d = BS_RA;
			end
			BS_RA: begin
				if ((it_q.aop == AL_DIV || it_q.aop == AL_MOD) && b_q == 64'd0) begin
					fin_err  = 1'b1;
					err_code = ST_DIVZERO;
				end else begin
					alu_req.start = 1'b1;
					state_d       = BS_ALU;
				end
			end
			BS_ALU: begin
				if (alu_done) begin
					op_we  = 1'b1;
					fin_ok = 1'b1;
					if (it_q.cls == CL_PUSH) begin
						top_d = top_q + OP_CW'(1);
					end else begin
						op_wa = tm2[OP_AW-1:0];
						top_d = tm1;
					end
				end
			end
			BS_R1: begin
				fin_ok = 1'b1;
				case (it_q.cls)
					CL_NOT: begin
						op_we = 1'b1;
						op_wa = tm1[OP_AW-1:0];
						op_wd = {63'd0, op_rd == 64'd0};
					end
					CL_JMPF: begin
						top_d = tm1;
						if (op_rd == 64'd0) begin
							np_new = it_q.idx;
						end
					end
					default: begin
						top_d    = tm1;
						pv_new   = 1'b1;
						pval_new = op_rd;
					end
				endcase
			end
			BS_LINK: begin
				ltop_d  = lm1;
				ftop_d  = fbase_q;
				fbase_d = lk_rec.base;
				nf_new  = lk_rec.fn;
				np_new  = lk_rec.pc + 16'd1;
				fin_ok  = 1'b1;
			end
			BS_CPY: begin
				// read arguments from the top down, write them in the next cycle
				op_ra    = tmc[OP_AW-1:0];
				cpy_wa_d = cwa[LOC_AW-1:0];
				cnt_d    = cnt_q + 8'd1;
				if (cnt_q == it_q.argc - 8'd1) begin
					state_d = BS_CPYEND;
				end
			end
			BS_CPYEND: begin
				top_d   = top_q - OP_CW'(it_q.argc);
				fbase_d = ftop_q;
				ftop_d  = csum[LOC_CW-1:0];
				nf_new  = it_q.idx;
				np_new  = 16'd0;
				fin_ok  = 1'b1;
			end
			BS_OUT: begin
				if (ocnt_q != 2'd2) begin
					state_d = BS_IDLE;
				end
			end
			default: state_d = BS_IDLE;
		endcase

		if (fin_ok) begin
			fn_d    = nf_new;
			pc_d    = np_new;
			res_d   = '{nf: nf_new, np: np_new, pv: pv_new, pval: pval_new,
				halted: 1'b0, st: ST_OK};
			state_d = BS_OUT;
		end
		if (fin_err) begin
			halt_d  = 1'b1;
			hst_d   = err_code;
			res_d   = '{nf: fn_q, np: pc_q, pv: 1'b0, pval: 64'd0,
				halted: 1'b1, st: err_code};
			state_d = BS_OUT;
		end

		// configuration write; user must give it only while idle, not enforced here
		if (cfg_we) begin
			root_d = rsat[LOC_CW-1:0];
			if (ltop_q == '0) begin
				ftop_d = LOC_CW'(LSUM_W'(fbase_q) + rsat);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BS_IDLE;
			top_q    <= '0;
			fbase_q  <= '0;
			ftop_q   <= LOC_CW'(1);
			root_q   <= LOC_CW'(1);
			ltop_q   <= '0;
			fn_q     <= 16'd0;
			pc_q     <= 16'd0;
			halt_q   <= 1'b0;
			hst_q    <= ST_OK;
			cnt_q    <= 8'd0;
			cpy_wv_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			top_q    <= top_d;
			fbase_q  <= fbase_d;
			ftop_q   <= ftop_d;
			root_q   <= root_d;
			ltop_q   <= ltop_d;
			fn_q     <= fn_d;
			pc_q     <= pc_d;
			halt_q   <= halt_d;
			hst_q    <= hst_d;
			cnt_q    <= cnt_d;
			cpy_wv_q <= (state_q == BS_CPY);
		end
	end

	always_ff @(posedge clk) begin
		it_q     <= it_d;
		b_q      <= b_d;
		cpy_wa_q <= cpy_wa_d;
		res_q    <= res_d;
	end

	// two-entry result queue
	assign opush     = (state_q == BS_OUT) && (ocnt_q != 2'd2);
	assign res_empty = (ocnt_q == 2'd0);
	assign res       = oq_q[orp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q  <= 1'b0;
			orp_q  <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (opush) begin
				owp_q <= ~owp_q;
			end
			if (res_pop && !res_empty) begin
				orp_q <= ~orp_q;
			end
			ocnt_q <= ocnt_q + {1'b0, opush} - {1'b0, res_pop && !res_empty};
		end
	end

	always_ff @(posedge clk) begin
		if (opush) begin
			oq_q[owp_q] <= res_q;
		end
	end

endmodule

### rtl/smx_checker.sv
// Port-level checker for the stack machine execute unit, bound to the top level.
`timescale 1ns / 1ps
module smx_checker import smx_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [15:0] next_func,
	input logic [15:0] next_pc,
	input logic        print_valid,
	input logic [63:0] print_value,
	input logic        halted,
	input logic [2:0]  status
);

	// a waiting result stays until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty) else $error("result beat dropped");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(next_pc) && $stable(next_func) && $stable(status))
		else $error("stalled result changed");

	// a printing beat never halts
	a_print: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && print_valid |-> !halted) else $error("print on halted beat");

	// any error status halts
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && status != ST_OK |-> halted) else $error("error without halt");

	// print value is zero unless printing
	a_pval: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !print_valid |-> print_value == 64'd0) else $error("stray print value");

endmodule

bind stack_machine_execute_unit smx_checker u_smx_checker (.*);

### test/stack_machine_execute_unit_tb.sv
// Self-checking testbench for the stack machine execute unit.
`timescale 1ns / 1ps
module stack_machine_execute_unit_tb;
	import smx_pkg::*;

	localparam logic [4:0] UNKNOWN_OPS [8] = '{5'd5, 5'd7, 5'd17, 5'd19, 5'd21, 5'd29,
		5'd30, 5'd31};
	localparam logic [63:0] ALL_ONES = {64{1'b1}};
	localparam int ITEMS = 1850;

	typedef struct {
		logic [4:0]  opcode;
		logic [15:0] idx;
		logic [63:0] imm;
		logic [10:0] cfw;
		logic [7:0]  argc;
		result_t     want;
	} beat_t;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [4:0]  opcode;
	logic [15:0] index_field;
	logic [63:0] immediate;
	logic [10:0] callee_frame_words;
	logic [7:0]  callee_arg_count;
	logic        root_frame_words_we;
	logic [10:0] root_frame_words;
	logic        empty;
	logic        pop;
	logic [15:0] next_func;
	logic [15:0] next_pc;
	logic        print_valid;
	logic [63:0] print_value;
	logic        halted;
	logic [2:0]  status;

	stack_machine_execute_unit uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .opcode(opcode),
		.index_field(index_field), .immediate(immediate),
		.callee_frame_words(callee_frame_words), .callee_arg_count(callee_arg_count),
		.root_frame_words_we(root_frame_words_we), .root_frame_words(root_frame_words),
		.empty(empty), .pop(pop), .next_func(next_func), .next_pc(next_pc),
		.print_valid(print_valid), .print_value(print_value), .halted(halted),
		.status(status)
	);

	// machine state mirrored by the predictor
	logic [63:0] opnd_mem [OPERAND_DEPTH];
	logic [63:0] loc_mem [LOCAL_DEPTH];
	bit          loc_written [LOCAL_DEPTH];
	logic [15:0] lk_fn [CALL_DEPTH];
	logic [15:0] lk_pc [CALL_DEPTH];
	int          lk_base [CALL_DEPTH];
	int          opnd_top, fr_base, fr_top, lk_top, root_words;
	logic [15:0] cur_fn, cur_pc;
	bit          is_halted;
	status_t     held_st;

	beat_t   pending [$];
	result_t awaited [$];
	result_t drive_want;
	int      fails;
	int      send_gap, take_gap;
	bit      calm;

	// clock
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// apply a root frame write to the mirrored state
	function automatic void set_root(logic [10:0] v);
		root_words = (v == 0) ? 1 : ((v > LOCAL_DEPTH) ? LOCAL_DEPTH : int'(v));
		if (lk_top == 0)
			fr_top = fr_base + root_words;
	endfunction

	// execute one instruction on the mirrored state and return its result beat
	function automatic result_t execute(beat_t b);
		result_t     r;
		status_t     st;
		bit          stop, is_local, is_bin;
		logic [63:0] lv, a, c, v;
		int          nb, i;
		st = ST_OK;
		stop = 0;
		lv = '0;
		r.pv = 0;
		r.pval = '0;
		r.nf = cur_fn;
		r.np = cur_pc + 16'd1;
		if (is_halted) begin
			r.np = cur_pc;
			r.halted = 1;
			r.st = held_st;
			return r;
		end
		is_local = b.opcode inside {OP_LDL, OP_LTI, OP_ADDI, OP_SUBI};
		is_bin = b.opcode inside {OP_LT, OP_GT, OP_EQ, OP_NE, OP_ADD, OP_SUB, OP_MUL,
			OP_DIV, OP_MOD};
		if (is_local) begin
			if (fr_base + int'(b.idx) >= fr_top)
				st = ST_FRAME;
			else
				lv = loc_mem[(fr_base + b.idx) % LOCAL_DEPTH];
		end
		if (st == ST_OK && (is_local || b.opcode == OP_PUSH) && opnd_top >= OPERAND_DEPTH)
			st = ST_OVER;
		if (st == ST_OK && is_bin && opnd_top < 2)
			st = ST_UNDER;
		if (st == ST_OK && b.opcode inside {OP_NOT, OP_JMPF, OP_PRINT} && opnd_top < 1)
			st = ST_UNDER;
		if (st == ST_OK) begin
			if (is_bin) begin
				c = opnd_mem[opnd_top - 1];
				a = opnd_mem[opnd_top - 2];
			end
			case (b.opcode)
				OP_NOOP: ;
				OP_LDL: begin
					opnd_mem[opnd_top] = lv;
					opnd_top++;
				end
				OP_PUSH: begin
					opnd_mem[opnd_top] = b.imm;
					opnd_top++;
				end
				OP_LTI: begin
					opnd_mem[opnd_top] = (lv < b.imm) ? 64'd1 : 64'd0;
					opnd_top++;
				end
				OP_ADDI: begin
					opnd_mem[opnd_top] = lv + b.imm;
					opnd_top++;
				end
				OP_SUBI: begin
					opnd_mem[opnd_top] = lv - b.imm;
					opnd_top++;
				end
				OP_LT, OP_GT, OP_EQ, OP_NE, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
					if (b.opcode inside {OP_DIV, OP_MOD} && c == 0) begin
						st = ST_DIVZERO;
					end else begin
						case (b.opcode)
							OP_LT:   v = (a < c) ? 64'd1 : 64'd0;
							OP_GT:   v = (a > c) ? 64'd1 : 64'd0;
							OP_EQ:   v = (a == c) ? 64'd1 : 64'd0;
							OP_NE:   v = (a != c) ? 64'd1 : 64'd0;
							OP_ADD:  v = a + c;
							OP_SUB:  v = a - c;
							OP_MUL:  v = a * c;
							OP_DIV:  v = a / c;
							default: v = a % c;
						endcase
						opnd_top--;
						opnd_mem[opnd_top - 1] = v;
					end
				end
				OP_NOT: opnd_mem[opnd_top - 1] = (opnd_mem[opnd_top - 1] == 0) ? 64'd1 : 64'd0;
				OP_JMPF: begin
					opnd_top--;
					if (opnd_mem[opnd_top] == 0)
						r.np = b.idx;
				end
				OP_RET: begin
					if (lk_top == 0) begin
						st = ST_UNDER;
					end else begin
						lk_top--;
						fr_top = fr_base;
						r.nf = lk_fn[lk_top];
						r.np = lk_pc[lk_top] + 16'd1;
						fr_base = lk_base[lk_top];
					end
				end
				OP_CALL: begin
					nb = fr_top;
					if (lk_top >= CALL_DEPTH || nb + int'(b.cfw) > LOCAL_DEPTH || b.argc > b.cfw)
						st = ST_FRAME;
					else if (opnd_top < int'(b.argc))
						st = ST_UNDER;
					else begin
						lk_fn[lk_top] = cur_fn;
						lk_pc[lk_top] = cur_pc;
						lk_base[lk_top] = fr_base;
						lk_top++;
						// copy arguments, last popped lands in slot zero
						for (i = 0; i < int'(b.argc); i++) begin
							opnd_top--;
							loc_mem[(nb + b.argc - 1 - i) % LOCAL_DEPTH] = opnd_mem[opnd_top];
							loc_written[(nb + b.argc - 1 - i) % LOCAL_DEPTH] = 1;
						end
						fr_base = nb;
						fr_top = nb + b.cfw;
						r.nf = b.idx;
						r.np = 16'd0;
					end
				end
				OP_PRINT: begin
					opnd_top--;
					r.pv = 1;
					r.pval = opnd_mem[opnd_top];
				end
				OP_STR0, OP_STR1, OP_STR2: st = ST_UNSUP;
				OP_EXIT: stop = 1;
				default: st = ST_UNKNOWN;
			endcase
		end
		if (st != ST_OK || stop) begin
			stop = 1;
			is_halted = 1;
			held_st = st;
			r.nf = cur_fn;
			r.np = cur_pc;
			r.pv = 0;
			r.pval = '0;
		end else begin
			cur_fn = r.nf;
			cur_pc = r.np;
		end
		r.halted = stop;
		r.st = st;
		return r;
	endfunction

	function automatic beat_t noise_beat();
		beat_t b;
		b.opcode = 5'($urandom);
		b.idx = 16'($urandom);
		b.imm = {$urandom, $urandom};
		b.cfw = 11'($urandom);
		b.argc = 8'($urandom);
		return b;
	endfunction

	function automatic logic [63:0] pick_imm();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return ALL_ONES;
			2: return 64'd1 << 63;
			3: return 64'($urandom_range(0, 9));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// predict a beat and queue it for the driver
	function automatic void queue_beat(beat_t b);
		b.want = execute(b);
		pending.push_back(b);
	endfunction

	function automatic void queue_op(logic [4:0] op, logic [15:0] idx, logic [63:0] imm,
			logic [10:0] cfw, logic [7:0] argc);
		beat_t b;
		b = noise_beat();
		b.opcode = op;
		b.idx = idx;
		b.imm = imm;
		b.cfw = cfw;
		b.argc = argc;
		queue_beat(b);
	endfunction

	// queue one operation with random fields
	function automatic void queue_noise(logic [4:0] op);
		beat_t b;
		b = noise_beat();
		b.opcode = op;
		queue_beat(b);
	endfunction

	// draw an instruction that keeps the machine running
	function automatic beat_t legal_beat();
		beat_t b;
		int    rel, room, n;
		b = noise_beat();
		repeat (60) begin
			case ($urandom_range(0, 10))
				0: begin
					b.opcode = OP_NOOP;
					return b;
				end
				1, 2: if (opnd_top < 40) begin
					b.opcode = OP_PUSH;
					b.imm = pick_imm();
					return b;
				end
				3: if (opnd_top < 40 && fr_top > fr_base) begin
					repeat (8) begin
						rel = $urandom_range(0, fr_top - fr_base - 1);
						if (loc_written[(fr_base + rel) % LOCAL_DEPTH]) begin
							case ($urandom_range(0, 3))
								0: b.opcode = OP_LDL;
								1: b.opcode = OP_LTI;
								2: b.opcode = OP_ADDI;
								default: b.opcode = OP_SUBI;
							endcase
							b.idx = 16'(rel);
							b.imm = pick_imm();
							return b;
						end
					end
				end
				4, 5: if (opnd_top >= 2) begin
					case ($urandom_range(0, 8))
						0: b.opcode = OP_LT;
						1: b.opcode = OP_GT;
						2: b.opcode = OP_EQ;
						3: b.opcode = OP_NE;
						4: b.opcode = OP_ADD;
						5: b.opcode = OP_SUB;
						6: b.opcode = OP_MUL;
						7: b.opcode = OP_DIV;
						default: b.opcode = OP_MOD;
					endcase
					if (!(b.opcode inside {OP_DIV, OP_MOD}) || opnd_mem[opnd_top - 1] != 0)
						return b;
				end
				6: if (opnd_top >= 1) begin
					b.opcode = OP_NOT;
					return b;
				end
				7: if (opnd_top >= 1) begin
					b.opcode = OP_JMPF;
					return b;
				end
				8: if (opnd_top >= 1) begin
					b.opcode = OP_PRINT;
					return b;
				end
				9: if (lk_top > 0) begin
					b.opcode = OP_RET;
					return b;
				end
				default: if (lk_top < CALL_DEPTH && fr_top < LOCAL_DEPTH) begin
					room = LOCAL_DEPTH - fr_top;
					b.opcode = OP_CALL;
					b.cfw = 11'($urandom_range(1, (room < 8) ? room : 8));
					n = (opnd_top < int'(b.cfw)) ? opnd_top : int'(b.cfw);
					b.argc = 8'($urandom_range(0, n));
					return b;
				end
			endcase
		end
		b.opcode = OP_NOOP;
		return b;
	endfunction

	// fill the stack and make a call that copies the widest argument list
	function automatic void queue_wide_call();
		int room;
		room = LOCAL_DEPTH - fr_top;
		if (lk_top >= CALL_DEPTH || room < 255 || opnd_top > 500)
			return;
		while (opnd_top < 255)
			queue_noise(OP_PUSH);
		queue_op(OP_CALL, 16'($urandom), '0,
			11'($urandom_range(255, (room < 400) ? room : 400)), 8'd255);
	endfunction

	task automatic drain();
		while (pending.size() != 0 || push || awaited.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_root(logic [10:0] v);
		drain();
		@(posedge clk);
		root_frame_words_we <= 1'b1;
		root_frame_words <= v;
		@(posedge clk);
		root_frame_words_we <= 1'b0;
		set_root(v);
	endtask

	// one terminal condition per run, picked by the caller
	function automatic void queue_halt(int kind);
		beat_t b;
		b = noise_beat();
		case (kind)
			0: b.opcode = UNKNOWN_OPS[$urandom_range(0, 7)];
			1: begin
				while (opnd_top > 1)
					queue_noise(OP_PRINT);
				b.opcode = ($urandom_range(0, 1)) ? OP_ADD : OP_PRINT;
				if (opnd_top == 1 && b.opcode == OP_PRINT)
					b.opcode = OP_MUL;
			end
			2: begin
				while (lk_top > 0)
					queue_noise(OP_RET);
				b.opcode = OP_RET;
			end
			3: begin
				while (opnd_top < OPERAND_DEPTH)
					queue_noise(OP_PUSH);
				b.opcode = OP_PUSH;
			end
			4: begin
				b.opcode = OP_LDL;
				b.idx = (fr_top - fr_base >= 65535) ? 16'hFFFF :
					16'($urandom_range(fr_top - fr_base, 65535));
			end
			5: begin
				b.opcode = OP_CALL;
				b.cfw = 11'd1024;
			end
			6: begin
				queue_noise(OP_PUSH);
				queue_op(OP_PUSH, 16'($urandom), '0, 11'($urandom), 8'($urandom));
				b.opcode = ($urandom_range(0, 1)) ? OP_DIV : OP_MOD;
			end
			7: b.opcode = 5'(OP_STR0 + $urandom_range(0, 2));
			default: b.opcode = OP_EXIT;
		endcase
		queue_beat(b);
		// halted machine repeats itself
		repeat (6)
			queue_beat(noise_beat());
	endfunction

	// send beats with random gaps, holding while full
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			send_gap <= 0;
			calm <= 0;
		end else if (!push || !full) begin
			beat_t b;
			if (push)
				awaited.push_back(drive_want);
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				push <= 1'b0;
			end else if (pending.size() != 0) begin
				b = pending.pop_front();
				opcode <= b.opcode;
				index_field <= b.idx;
				immediate <= b.imm;
				callee_frame_words <= b.cfw;
				callee_arg_count <= b.argc;
				drive_want <= b.want;
				push <= 1'b1;
				if ($urandom_range(0, 63) == 0)
					calm <= !calm;
				send_gap <= calm ? 0 : $urandom_range(0, 6);
			end else begin
				push <= 1'b0;
			end
		end
	end

	// take result beats with random stalls and check them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			take_gap <= 0;
		end else if (pop && !empty) begin
			result_t w;
			int g;
			if (awaited.size() == 0) begin
				fails++;
				$display("%0t: unexpected result nf=%h np=%h pv=%b pval=%h halted=%b st=%0d",
					$time, next_func, next_pc, print_valid, print_value, halted, status);
			end else begin
				w = awaited.pop_front();
				if (next_func !== w.nf || next_pc !== w.np || print_valid !== w.pv ||
						print_value !== w.pval || halted !== w.halted || status !== w.st) begin
					fails++;
					$display("%0t: expected nf=%h np=%h pv=%b pval=%h halted=%b st=%0d",
						$time, w.nf, w.np, w.pv, w.pval, w.halted, w.st);
					$display("%0t:   actual nf=%h np=%h pv=%b pval=%h halted=%b st=%0d",
						$time, next_func, next_pc, print_valid, print_value, halted,
						status);
				end
			end
			g = calm ? 0 : $urandom_range(0, 6);
			take_gap <= g;
			pop <= (g == 0);
		end else if (take_gap != 0) begin
			take_gap <= take_gap - 1;
			pop <= (take_gap == 1);
		end else begin
			pop <= 1'b1;
		end
	end

	initial begin
		logic [10:0] roots [6];
		int k;
		int halt_kind;
		int phase_len;
		fails = 0;
		opnd_top = 0;
		fr_base = 0;
		lk_top = 0;
		root_words = 1;
		fr_top = 1;
		cur_fn = '0;
		cur_pc = '0;
		is_halted = 0;
		held_st = ST_OK;
		foreach (loc_written[i])
			loc_written[i] = 0;
		arst_n = 1'b0;
		opcode = '0;
		index_field = '0;
		immediate = '0;
		callee_frame_words = '0;
		callee_arg_count = '0;
		root_frame_words_we = 1'b0;
		root_frame_words = '0;
		// size the random phases so the whole run stays near the item budget
		halt_kind = $urandom_range(0, 8);
		phase_len = (ITEMS - 300 - ((halt_kind == 3) ? OPERAND_DEPTH : 0)) / 6;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: every non-halting operation, edge operands and a call with arguments
		write_root(11'd0);
		queue_op(OP_PUSH, 16'd0, '0, 11'd0, 8'd0);
		queue_op(OP_PUSH, 16'hFFFF, ALL_ONES, 11'h7FF, 8'hFF);
		queue_op(OP_ADD, 16'd0, '0, 11'd0, 8'd0);
		queue_op(OP_PUSH, 16'd0, 64'd2, 11'd0, 8'd0);
		queue_op(OP_MUL, 16'd0, '0, 11'd0, 8'd0);
		queue_op(OP_PUSH, 16'd0, 64'd1 << 63, 11'd0, 8'd0);
		queue_op(OP_LT, 16'd0, '0, 11'd0, 8'd0);
		queue_op(OP_PUSH, 16'd0, 64'd7, 11'd0, 8'd0);
		queue_op(OP_GT, 16'd0, '0, 11'd0, 8'd0);
		queue_op(OP_PUSH, 16'd0, '0, 11'd0, 8'd0);
		queue_op(OP_EQ, 16'd0, '0, 11'd0, 8'd0);
		queue_op(OP_PUSH, 16'd0, 64'd5, 11'd0, 8'd0);
		queue_op(OP_NE, 16'd0, '0, 11'd0, 8'd0);
		queue_op(OP_NOT, 16'd0, '0, 11'd0, 8'd0);
		queue_op(OP_JMPF, 16'hFFFF, '0, 11'd0, 8'd0);
		queue_op(OP_PUSH, 16'd0, 64'd100, 11'd0, 8'd0);
		queue_op(OP_PUSH, 16'd0, 64'd7, 11'd0, 8'd0);
		queue_op(OP_DIV, 16'd0, '0, 11'd0, 8'd0);
		queue_op(OP_PUSH, 16'd0, 64'd9, 11'd0, 8'd0);
		queue_op(OP_MOD, 16'd0, '0, 11'd0, 8'd0);
		queue_op(OP_PUSH, 16'd0, '0, 11'd0, 8'd0);
		queue_op(OP_PUSH, 16'd0, 64'd1, 11'd0, 8'd0);
		queue_op(OP_SUB, 16'd0, '0, 11'd0, 8'd0);
		queue_op(OP_CALL, 16'hFFFF, '0, 11'd3, 8'd2);
		queue_op(OP_LDL, 16'd0, '0, 11'd0, 8'd0);
		queue_op(OP_LTI, 16'd1, ALL_ONES, 11'd0, 8'd0);
		queue_op(OP_ADDI, 16'd0, ALL_ONES, 11'd0, 8'd0);
		queue_op(OP_SUBI, 16'd1, ALL_ONES, 11'd0, 8'd0);
		queue_op(OP_PRINT, 16'd0, '0, 11'd0, 8'd0);
		queue_op(OP_RET, 16'd0, '0, 11'd0, 8'd0);
		queue_op(OP_NOOP, 16'hFFFF, ALL_ONES, 11'h7FF, 8'hFF);

		// random phases under several root frame sizes
		roots = '{11'h7FF, 11'd1024, 11'd1, 11'd0, 11'd5, 11'd0};
		roots[3] = 11'($urandom_range(1, 1023));
		foreach (roots[p]) begin
			write_root(roots[p]);
			for (k = 0; k < phase_len; k++) begin
				if (p == 2 && k == phase_len / 2)
					queue_wide_call();
				queue_beat(legal_beat());
			end
		end

		queue_halt(halt_kind);
		drain();
		repeat (100) @(posedge clk);
		if (fails == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// hold-off for a hung run
	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
